@@ hdl/generational_slot_allocator_defines.svh @@
// Assertion macros used by the generational slot allocator RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_DEFINES_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define GSA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slot allocator check failed");

// Next-cycle implication, disabled while reset is high.
`define GSA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slot allocator check failed");

`endif

@@ hdl/gsa_pkg.sv @@
// Types and constants of the generational slot allocator.
// Used by gsa_front, gsa_rspq, gsa_back and the top level; depends on nothing.
`default_nettype none

package gsa_pkg;

   // Pool geometry.
   localparam int POOL_SIZE     = 128;
   localparam int IDX_BITS      = $clog2(POOL_SIZE);
   localparam int STK_CNT_BITS  = $clog2(POOL_SIZE + 1);
   localparam int GEN_BITS      = 16;
   localparam int PAYLOAD_BITS  = 64;
   localparam int STK_BITS      = IDX_BITS + GEN_BITS;

   // Short queues between the stages.
   localparam int Q_DEPTH       = 2;
   localparam int Q_PTR_BITS    = $clog2(Q_DEPTH);
   localparam int Q_CNT_BITS    = $clog2(Q_DEPTH + 1);

   typedef logic [IDX_BITS-1:0] idx_type;
   typedef logic [GEN_BITS-1:0] gen_type;

   typedef enum logic [1:0] {
      ST_GRANTED  = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_RELEASED = 2'd2,
      ST_IGNORED  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_ACQUIRE = 2'd0,
      OP_RELEASE = 2'd1,
      OP_REJECT  = 2'd2
   } op_type;

   localparam logic MODE_ACQUIRE = 1'b0;

   typedef struct packed {
      logic        mode;
      logic [31:0] spawn_x;
      logic [31:0] spawn_y;
      idx_type     handle_index;
      gen_type     handle_generation;
   } req_type;

   typedef struct packed {
      status_type  status;
      idx_type     slot_index;
      gen_type     slot_generation;
   } rsp_type;

   // Classified request handed from the front end to the back end.
   typedef struct packed {
      op_type      op;
      logic [31:0] spawn_x;
      logic [31:0] spawn_y;
      idx_type     handle_index;
      gen_type     handle_generation;
   } cmd_type;

   // Free stack entry: a free slot together with its current generation.
   typedef struct packed {
      idx_type     index;
      gen_type     generation;
   } stk_entry_type;

   // Payload store write port.
   typedef struct packed {
      logic                    en;
      idx_type                 addr;
      logic [PAYLOAD_BITS-1:0] data;
   } pay_wr_type;

endpackage

`default_nettype wire

@@ hdl/gsa_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module gsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and read-before-write in the same edge.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/gsa_front.sv @@
// Front end: takes request transfers, classifies them and queues them.
// Depends on gsa_pkg.
`default_nettype none

module gsa_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire gsa_pkg::req_type req,
   output logic                  cmd_valid,
   input  wire logic             cmd_pop,
   output gsa_pkg::cmd_type      cmd
);

   gsa_pkg::cmd_type                    entry_ff [gsa_pkg::Q_DEPTH];
   logic [gsa_pkg::Q_PTR_BITS-1:0]      wptr_ff, wptr_in;
   logic [gsa_pkg::Q_PTR_BITS-1:0]      rptr_ff, rptr_in;
   logic [gsa_pkg::Q_CNT_BITS-1:0]      count_ff, count_in;
   gsa_pkg::cmd_type                    classified;
   logic                                do_push;
   logic                                do_pop;

   // Classify the request: acquire, release of a real slot, or a release
   // whose index lies outside the pool.
   always_comb begin
      classified.spawn_x           = req.spawn_x;
      classified.spawn_y           = req.spawn_y;
      classified.handle_index      = req.handle_index;
      classified.handle_generation = req.handle_generation;
      if (req.mode == gsa_pkg::MODE_ACQUIRE) begin
         classified.op = gsa_pkg::OP_ACQUIRE;
      end else if (int'(req.handle_index) < gsa_pkg::POOL_SIZE) begin
         classified.op = gsa_pkg::OP_RELEASE;
      end else begin
         classified.op = gsa_pkg::OP_REJECT;
      end
   end

   assign full      = (count_ff == gsa_pkg::Q_CNT_BITS'(gsa_pkg::Q_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = entry_ff[rptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   // Queue pointers and fill count.
   always_comb begin
      wptr_in  = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop  ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= classified;
      end
   end

endmodule

`default_nettype wire

@@ hdl/gsa_rspq.sv @@
// Result queue: holds finished results until the consumer takes them.
// Depends on gsa_pkg.
`default_nettype none

module gsa_rspq (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire gsa_pkg::rsp_type din,
   output logic                  full,
   output logic                  empty,
   input  wire logic             pop,
   output gsa_pkg::rsp_type      dout
);

   gsa_pkg::rsp_type                    entry_ff [gsa_pkg::Q_DEPTH];
   logic [gsa_pkg::Q_PTR_BITS-1:0]      wptr_ff, wptr_in;
   logic [gsa_pkg::Q_PTR_BITS-1:0]      rptr_ff, rptr_in;
   logic [gsa_pkg::Q_CNT_BITS-1:0]      count_ff, count_in;
   logic                                do_push;
   logic                                do_pop;

   assign full    = (count_ff == gsa_pkg::Q_CNT_BITS'(gsa_pkg::Q_DEPTH));
   assign empty   = (count_ff == '0);
   assign dout    = entry_ff[rptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Queue pointers and fill count.
   always_comb begin
      wptr_in  = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop  ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= din;
      end
   end

endmodule

`default_nettype wire

@@ hdl/gsa_back.sv @@
// Back end: carries out acquire and release commands against the free
// stack, the generation store and the in-use marks. Depends on gsa_pkg
// and gsa_ram.
`default_nettype none

module gsa_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   output logic                  cmd_pop,
   input  wire gsa_pkg::cmd_type cmd,
   output logic                  rsp_push,
   output gsa_pkg::rsp_type      rsp,
   input  wire logic             rsp_full,
   output gsa_pkg::pay_wr_type   pay_wr
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type                          state_ff, state_in;
   gsa_pkg::cmd_type                   cmd_ff;
   logic [gsa_pkg::STK_CNT_BITS-1:0]   count_ff, count_in;
   logic [gsa_pkg::POOL_SIZE-1:0]      stk_mark_ff, stk_mark_in;
   logic [gsa_pkg::POOL_SIZE-1:0]      gen_mark_ff, gen_mark_in;
   logic [gsa_pkg::POOL_SIZE-1:0]      in_use_ff, in_use_in;
   gsa_pkg::idx_type                   pos_ff;
   logic                               stk_valid_ff;
   logic                               gen_valid_ff;
   logic                               in_use_hit_ff;

   logic                               issue;
   gsa_pkg::idx_type                   rd_pos;
   logic                               stk_wr_en;
   gsa_pkg::idx_type                   stk_wr_addr;
   gsa_pkg::stk_entry_type             stk_wr_data;
   logic [gsa_pkg::STK_BITS-1:0]       stk_rd_data;
   logic                               gen_wr_en;
   gsa_pkg::gen_type                   gen_wr_data;
   gsa_pkg::gen_type                   gen_rd_data;
   gsa_pkg::stk_entry_type             top_entry;
   gsa_pkg::gen_type                   gen_cur;
   gsa_pkg::gen_type                   gen_next;

   // Position of the top of the stack; only used when the stack holds a slot.
   assign rd_pos = gsa_pkg::IDX_BITS'(count_ff - gsa_pkg::STK_CNT_BITS'(1));

   // An entry never written is read as its reset value: descending indices
   // with generation zero.
   always_comb begin
      if (stk_valid_ff) begin
         top_entry = gsa_pkg::stk_entry_type'(stk_rd_data);
      end else begin
         top_entry.index      = gsa_pkg::IDX_BITS'(gsa_pkg::POOL_SIZE - 1) - pos_ff;
         top_entry.generation = '0;
      end
   end

   assign gen_cur  = gen_valid_ff ? gen_rd_data : '0;
   assign gen_next = gen_cur + 1'b1;

   // Command sequencer: read the stores on issue in S_IDLE, update them in S_EXEC once the result queue has room.
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      stk_mark_in = stk_mark_ff;
      gen_mark_in = gen_mark_ff;
      in_use_in   = in_use_ff;
      issue       = 1'b0;
      cmd_pop     = 1'b0;
      rsp_push    = 1'b0;
      rsp.status          = gsa_pkg::ST_IGNORED;
      rsp.slot_index      = '0;
      rsp.slot_generation = '0;
      stk_wr_en   = 1'b0;
      stk_wr_addr = count_ff[gsa_pkg::IDX_BITS-1:0];
      stk_wr_data.index      = cmd_ff.handle_index;
      stk_wr_data.generation = gen_next;
      gen_wr_en   = 1'b0;
      gen_wr_data = gen_next;
      pay_wr.en   = 1'b0;
      pay_wr.addr = top_entry.index;
      pay_wr.data = {cmd_ff.spawn_x, cmd_ff.spawn_y};
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               issue    = 1'b1;
               cmd_pop  = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
               case (cmd_ff.op)
                  gsa_pkg::OP_ACQUIRE: begin
                     if (count_ff == '0) begin
                        rsp.status = gsa_pkg::ST_EMPTY;
                     end else begin
                        count_in                    = count_ff - 1'b1;
                        in_use_in[top_entry.index]  = 1'b1;
                        pay_wr.en                   = !reset;
                        rsp.status                  = gsa_pkg::ST_GRANTED;
                        rsp.slot_index              = top_entry.index;
                        rsp.slot_generation         = top_entry.generation;
                     end
                  end
                  gsa_pkg::OP_RELEASE: begin
                     if (in_use_hit_ff &&
                         gen_cur == cmd_ff.handle_generation) begin
                        rsp.status                         = gsa_pkg::ST_RELEASED;
                        in_use_in[cmd_ff.handle_index]     = 1'b0;
                        gen_wr_en                          = !reset;
                        gen_mark_in[cmd_ff.handle_index]   = 1'b1;
                        // Push the freed slot with its new generation.
                        if (count_ff < gsa_pkg::STK_CNT_BITS'(gsa_pkg::POOL_SIZE)) begin
                           stk_wr_en                = !reset;
                           stk_mark_in[stk_wr_addr] = 1'b1;
                           count_in                 = count_ff + 1'b1;
                        end
                     end
                  end
                  default: begin
                     rsp.status = gsa_pkg::ST_IGNORED;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= gsa_pkg::STK_CNT_BITS'(gsa_pkg::POOL_SIZE);
         stk_mark_ff <= '0;
         gen_mark_ff <= '0;
         in_use_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         stk_mark_ff <= stk_mark_in;
         gen_mark_ff <= gen_mark_in;
         in_use_ff   <= in_use_in;
      end
   end

   // Command and read context captured at issue.
   always_ff @(posedge clock) begin
      if (issue) begin
         cmd_ff        <= cmd;
         pos_ff        <= rd_pos;
         stk_valid_ff  <= stk_mark_ff[rd_pos];
         gen_valid_ff  <= gen_mark_ff[cmd.handle_index];
         in_use_hit_ff <= in_use_ff[cmd.handle_index];
      end
   end

   // Free stack of slot index and generation.
   gsa_ram #(
      .WIDTH (gsa_pkg::STK_BITS),
      .DEPTH (gsa_pkg::POOL_SIZE)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (issue),
      .rd_addr (rd_pos),
      .rd_data (stk_rd_data)
   );

   // Current generation of each slot.
   gsa_ram #(
      .WIDTH (gsa_pkg::GEN_BITS),
      .DEPTH (gsa_pkg::POOL_SIZE)
   ) u_gen_ram (
      .clock   (clock),
      .wr_en   (gen_wr_en),
      .wr_addr (cmd_ff.handle_index),
      .wr_data (gen_wr_data),
      .rd_en   (issue),
      .rd_addr (cmd.handle_index),
      .rd_data (gen_rd_data)
   );

endmodule

`default_nettype wire

@@ hdl/generational_slot_allocator.sv @@
// Top level of the generational slot allocator: front end, back end,
// result queue and payload store. Depends on gsa_pkg, gsa_ram, gsa_front,
// gsa_back, gsa_rspq and generational_slot_allocator_defines.svh.
//
// A pool of 128 slots handed out through a LIFO free stack; every handle is
// an index plus a 16-bit generation, and a release only frees a slot that is
// in use and whose generation matches. Every request transfer produces
// exactly one result transfer, in order. The back end handles each request
// in a read step, which reads the free stack and generation RAMs, and an
// update step, which writes them back once the result queue has room; it
// takes no new request until it has finished the last one. Two-entry
// queues on each side let requests and results wait independently of the
// back end. The stores come out of reset ready to use, with no clearing
// pass.
`default_nettype none
`include "generational_slot_allocator_defines.svh"

module generational_slot_allocator (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   output logic                  full,
   input  wire gsa_pkg::req_type req_data,
   output logic                  empty,
   input  wire logic             pop,
   output gsa_pkg::rsp_type      rsp_data
);

   logic                                cmd_valid;
   logic                                cmd_pop;
   gsa_pkg::cmd_type                    cmd;
   logic                                rsp_push;
   gsa_pkg::rsp_type                    rsp;
   logic                                rsp_full;
   gsa_pkg::pay_wr_type                 pay_wr;
   gsa_pkg::idx_type                    pay_rd_addr_ff;
   logic [gsa_pkg::PAYLOAD_BITS-1:0]    pay_rd_data;

   gsa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req       (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd)
   );

   gsa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .rsp_push  (rsp_push),
      .rsp       (rsp),
      .rsp_full  (rsp_full),
      .pay_wr    (pay_wr)
   );

   gsa_rspq u_rspq (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .din   (rsp),
      .full  (rsp_full),
      .empty (empty),
      .pop   (pop),
      .dout  (rsp_data)
   );

   // The payload read port follows the last written slot.
   always_ff @(posedge clock) begin
      if (pay_wr.en) begin
         pay_rd_addr_ff <= pay_wr.addr;
      end
   end

   // Payload words of each acquired slot.
   gsa_ram #(
      .WIDTH (gsa_pkg::PAYLOAD_BITS),
      .DEPTH (gsa_pkg::POOL_SIZE)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (pay_wr.en),
      .wr_addr (pay_wr.addr),
      .wr_data (pay_wr.data),
      .rd_en   (1'b1),
      .rd_addr (pay_rd_addr_ff),
      .rd_data (pay_rd_data)
   );

   // Payload written on a grant reads back through the registered read address and read port.
   `GSA_ASSERT_NOW(a_payload_readback, clock, reset, $past(pay_wr.en, 2), pay_rd_data == $past(pay_wr.data, 2))
   // The back end never hands a result to a full result queue.
   `GSA_ASSERT_NOW(a_no_push_when_full, clock, reset, rsp_push, !rsp_full)
   // A command taken by the back end is never followed by another one at once.
   `GSA_ASSERT_NEXT(a_two_cycle_issue, clock, reset, cmd_pop, !cmd_pop)

endmodule

`default_nettype wire
